>>> rtl/core/bdq_pkg.sv
package bdq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_REMOVE     = 3'd4;
  localparam logic [2:0] REQ_CLEAR      = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
  } req_word_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic [1:0]         status;
    logic [4:0]         entry_count;
  } rsp_word_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_EXEC,
    CS_SCAN,
    CS_SHIFT,
    CS_MISS
  } ctrl_state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_EXEC,
    OP_LOAD_MATCH,
    OP_SCAN_NEXT,
    OP_REMOVE,
    OP_MISS
  } dp_op_e;

  typedef struct packed {
    logic   accept;
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_remove;
    logic empty;
    logic full;
    logic out_free;
    logic hit;
    logic scan_last;
  } dp_sts_t;

endpackage

>>> rtl/core/bdq_ctrl.sv
module bdq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  bdq_pkg::dp_sts_t sts,
  output bdq_pkg::dp_cmd_t cmd
);

  bdq_pkg::ctrl_state_e state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdq_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bdq_pkg::CS_IDLE: begin
        if (req_valid) state_next = bdq_pkg::CS_EXEC;
      end
      bdq_pkg::CS_EXEC: begin
        if (sts.is_remove && !sts.empty) state_next = bdq_pkg::CS_SCAN;
        else if (sts.out_free) state_next = bdq_pkg::CS_IDLE;
      end
      bdq_pkg::CS_SCAN: begin
        if (sts.hit) state_next = bdq_pkg::CS_SHIFT;
        else if (sts.scan_last) state_next = bdq_pkg::CS_MISS;
      end
      bdq_pkg::CS_SHIFT, bdq_pkg::CS_MISS: begin
        if (sts.out_free) state_next = bdq_pkg::CS_IDLE;
      end
      default: state_next = bdq_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    req_ready  = 1'b0;
    cmd.accept = 1'b0;
    cmd.op     = bdq_pkg::OP_NONE;
    case (state)
      bdq_pkg::CS_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
      end
      bdq_pkg::CS_EXEC: begin
        if (sts.is_remove && !sts.empty) cmd.op = bdq_pkg::OP_LOAD_MATCH;
        else if (sts.out_free) cmd.op = bdq_pkg::OP_EXEC;
      end
      bdq_pkg::CS_SCAN: begin
        if (!sts.hit && !sts.scan_last) cmd.op = bdq_pkg::OP_SCAN_NEXT;
      end
      bdq_pkg::CS_SHIFT: begin
        if (sts.out_free) cmd.op = bdq_pkg::OP_REMOVE;
      end
      bdq_pkg::CS_MISS: begin
        if (sts.out_free) cmd.op = bdq_pkg::OP_MISS;
      end
      default: begin
        cmd.op = bdq_pkg::OP_NONE;
      end
    endcase
  end

endmodule

>>> rtl/core/bdq_datapath.sv
module bdq_datapath (
  input  logic               clk,
  input  logic               rst,
  input  bdq_pkg::req_word_t req,
  input  bdq_pkg::dp_cmd_t   cmd,
  output bdq_pkg::dp_sts_t   sts,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output bdq_pkg::rsp_word_t rsp
);

  localparam int DEPTH = bdq_pkg::DEPTH;
  localparam int CNT_W = bdq_pkg::CNT_W;
  localparam int IDX_W = bdq_pkg::IDX_W;

  bdq_pkg::req_word_t req_q;
  logic [31:0]        entries [DEPTH];
  logic [DEPTH-1:0]   match;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   idx;

  logic [CNT_W-1:0]   count_m1;
  logic [IDX_W-1:0]   back_idx;
  logic               empty;
  logic               full;
  logic               load_rsp;
  bdq_pkg::rsp_word_t rsp_next;
  logic [CNT_W-1:0]   count_next;
  logic [CNT_W+4:0]   count_ext;

  assign empty    = (count == '0);
  assign full     = (count >= CNT_W'(DEPTH));
  assign count_m1 = count - 1'b1;
  assign back_idx = count_m1[IDX_W-1:0];

  assign sts.is_remove = (req_q.req_type == bdq_pkg::REQ_REMOVE);
  assign sts.empty     = empty;
  assign sts.full      = full;
  assign sts.out_free  = !rsp_valid || rsp_ready;
  assign sts.hit       = match[idx];
  assign sts.scan_last = (CNT_W'(idx) == count_m1);

  // count and response for the requests finished in EXEC and the two remove endings
  always_comb begin
    count_next            = count;
    load_rsp              = 1'b0;
    rsp_next.popped_value = '0;
    rsp_next.status       = bdq_pkg::ST_OK;
    case (cmd.op)
      bdq_pkg::OP_EXEC: begin
        load_rsp = 1'b1;
        case (req_q.req_type)
          bdq_pkg::REQ_PUSH_FRONT, bdq_pkg::REQ_PUSH_BACK: begin
            if (full) rsp_next.status = bdq_pkg::ST_FULL;
            else count_next = count + 1'b1;
          end
          bdq_pkg::REQ_POP_FRONT: begin
            if (empty) begin
              rsp_next.status = bdq_pkg::ST_EMPTY;
            end else begin
              rsp_next.popped_value = entries[0];
              count_next = count_m1;
            end
          end
          bdq_pkg::REQ_POP_BACK: begin
            if (empty) begin
              rsp_next.status = bdq_pkg::ST_EMPTY;
            end else begin
              rsp_next.popped_value = entries[back_idx];
              count_next = count_m1;
            end
          end
          bdq_pkg::REQ_REMOVE: rsp_next.status = bdq_pkg::ST_EMPTY;
          bdq_pkg::REQ_CLEAR:  count_next = '0;
          default: count_next = count;
        endcase
      end
      bdq_pkg::OP_REMOVE: begin
        load_rsp   = 1'b1;
        count_next = count_m1;
      end
      bdq_pkg::OP_MISS: begin
        load_rsp        = 1'b1;
        rsp_next.status = bdq_pkg::ST_NOTFOUND;
      end
      default: load_rsp = 1'b0;
    endcase
    count_ext            = {5'd0, count_next};
    rsp_next.entry_count = count_ext[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (load_rsp) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) req_q <= req;
    if (load_rsp) rsp <= rsp_next;

    case (cmd.op)
      bdq_pkg::OP_EXEC: begin
        if (req_q.req_type == bdq_pkg::REQ_PUSH_FRONT && !full) begin
          entries[0] <= req_q.value;
          for (int i = 1; i < DEPTH; i++) entries[i] <= entries[i-1];
        end
        if (req_q.req_type == bdq_pkg::REQ_PUSH_BACK && !full) begin
          entries[count[IDX_W-1:0]] <= req_q.value;
        end
        if (req_q.req_type == bdq_pkg::REQ_POP_FRONT && !empty) begin
          for (int i = 0; i < DEPTH - 1; i++) entries[i] <= entries[i+1];
        end
      end
      bdq_pkg::OP_LOAD_MATCH: begin
        idx <= '0;
        for (int i = 0; i < DEPTH; i++) match[i] <= (entries[i] == req_q.value);
      end
      bdq_pkg::OP_SCAN_NEXT: begin
        idx <= idx + 1'b1;
      end
      bdq_pkg::OP_REMOVE: begin
        // close the gap at the hit: every cell at or past it but the last takes its neighbor
        for (int i = 0; i < DEPTH - 1; i++) begin
          if (IDX_W'(i) >= idx) entries[i] <= entries[i+1];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/bounded_deque_with_remove.sv
// Ordered list of up to bdq_pkg::DEPTH signed 32-bit words with push and pop at
// either end, remove-first-match and clear; every request word gives one
// response word. One request is in work at a time: push, pop, clear, unused
// codes and a remove on an empty list go from accept straight to execute,
// which loads the response. Any other remove compares all entries at once
// into a registered match vector, then a scan index walks it one entry per
// cycle from the front. A finished response sits in an output register, and
// the next request is accepted while it waits; a request that reaches its last
// step while that register still holds an untaken word waits there until the
// word is taken.
module bounded_deque_with_remove (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  bdq_pkg::req_word_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output bdq_pkg::rsp_word_t rsp
);

  bdq_pkg::dp_cmd_t cmd;
  bdq_pkg::dp_sts_t sts;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bdq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second request accepted while one is in work");

  a_count_sane: assert property (@(posedge clk) disable iff (rst)
    !(sts.empty && sts.full))
    else $error("list reads both empty and full");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> (cmd.op == bdq_pkg::OP_NONE))
    else $error("datapath command issued while accepting requests");

  a_rsp_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == bdq_pkg::OP_EXEC || cmd.op == bdq_pkg::OP_REMOVE ||
     cmd.op == bdq_pkg::OP_MISS) |-> sts.out_free)
    else $error("response loaded over an untaken word");

endmodule
